/* rtl/core/ffpra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpra_pkg
// Shared types and constants of the first-fit page run allocator: request
// and response words, request and status codes, and the controller states.
// ----------------------------------------------------------------------------
package ffpra_pkg;

	// default heap size in pages
	localparam int HEAP_PAGES_DEF = 4096;

	// fixed field widths
	localparam int COUNT_W = 13;
	localparam int START_W = 12;

	// request kinds
	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} ffpra_kind_t;

	// response status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_NOMEM = 1'b1;

	// request word
	typedef struct packed {
		logic               req_type;
		logic [COUNT_W-1:0] page_count;
		logic [START_W-1:0] run_start;
	} ffpra_req_t;

	// response word
	typedef struct packed {
		logic [START_W-1:0] alloc_start;
		logic               status;
	} ffpra_rsp_t;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_TAKE,
		ST_PV_RD,
		ST_PV_WR,
		ST_NX_RD,
		ST_NX_WR,
		ST_CUR_CLR,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_RESP
	} ffpra_state_t;

endpackage

/* rtl/core/ffpra_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpra_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ffpra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/first_fit_page_run_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator_unit
// First-fit allocator of page runs over a heap of HEAP_PAGES pages, with a
// doubly linked free list kept in one descriptor RAM and a downward bump
// pointer for pages never handed out.
// ----------------------------------------------------------------------------
// One request word gives one response word. All descriptors live in a single
// RAM with one read and one write port and registered read data, so every
// link update is a read followed by a write. An allocate walks the free list
// entry by entry, then splits or unlinks the run it takes, or else takes
// pages from the bump pointer or fails. A free reads the descriptor at its
// start and pushes the run on the list head unless a free run starts there;
// a free that fails its range checks skips the read. A clearing pass after
// reset writes every descriptor, and no request is taken meanwhile. A new
// request is taken while the previous response waits in the output register.
// ----------------------------------------------------------------------------
module first_fit_page_run_allocator_unit #(
	parameter int HEAP_PAGES = ffpra_pkg::HEAP_PAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  ffpra_pkg::ffpra_req_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output ffpra_pkg::ffpra_rsp_t rsp
);
	import ffpra_pkg::*;

	localparam int AW    = $clog2(HEAP_PAGES);
	localparam int LW    = $clog2(HEAP_PAGES + 1);
	localparam int LEN_W = COUNT_W;
	localparam int WW    = LEN_W + 2 * LW;
	localparam int CW    = ((LW > LEN_W) ? LW : LEN_W) + 1;

	localparam logic [LW-1:0] NIL    = LW'(HEAP_PAGES);
	localparam logic [CW-1:0] HEAP_C = CW'(HEAP_PAGES);
	localparam logic [AW-1:0] LAST   = AW'(HEAP_PAGES - 1);

	// controller state
	ffpra_state_t state_q, state_d;

	// control registers
	logic [AW-1:0] clr_q;
	logic [LW-1:0] head_q;
	logic [LW-1:0] bump_q;
	logic          rsp_valid_q;

	// request and walk registers
	logic               kind_q;
	logic [LEN_W-1:0]   n_q;
	logic [START_W-1:0] start_q;
	logic [LW-1:0]      cur_q;
	logic [LW-1:0]      steps_q;
	logic [LEN_W-1:0]   len_q;
	logic [LW-1:0]      nx_q;
	logic [LW-1:0]      pv_q;
	logic [LW-1:0]      link_q;
	logic [LW-1:0]      nx_prev_q;
	logic [LW-1:0]      result_q;
	logic               status_q;
	ffpra_rsp_t         rsp_q;

	// descriptor ram ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [WW-1:0] mem_rdata;

	// descriptor fields of the read word
	logic [LEN_W-1:0] rd_len;
	logic [LW-1:0]    rd_next;
	logic [LW-1:0]    rd_prev;

	// decode helpers
	logic          in_free;
	logic          in_zero;
	logic          in_free_ok;
	logic          cur_live;
	logic          walk_more;
	logic          fit;
	logic          split;
	logic [CW-1:0] rem_sum;
	logic          rem_live;
	logic [LW-1:0] rem_idx;
	logic          link_ok;
	logic [LW-1:0] new_link;
	logic          pv_live;
	logic          nx_live;
	logic          head_live;
	logic          bump_fits;
	logic [LW-1:0] bump_new;
	logic [LW-1:0] start_idx;
	logic          rsp_load;

	ffpra_ram #(
		.WIDTH(WW),
		.DEPTH(HEAP_PAGES)
	) u_desc_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// split the read word into its fields
	assign rd_len  = mem_rdata[WW-1 -: LEN_W];
	assign rd_next = mem_rdata[2*LW-1 -: LW];
	assign rd_prev = mem_rdata[LW-1:0];

	// checks on an incoming word
	assign in_free    = (req.req_type == REQ_FREE);
	assign in_zero    = (req.page_count == '0);
	assign in_free_ok = !in_zero && (CW'(req.run_start) < HEAP_C) &&
		((CW'(req.page_count) + CW'(req.run_start)) <= HEAP_C);

	// walk and unlink helpers
	assign cur_live  = (CW'(cur_q) < HEAP_C);
	assign walk_more = cur_live && (steps_q < NIL);
	assign fit       = (rd_len >= n_q);
	assign split     = (len_q > n_q);
	assign rem_sum   = CW'(cur_q) + CW'(n_q);
	assign rem_live  = (rem_sum < HEAP_C);
	assign rem_idx   = LW'(rem_sum);
	assign link_ok   = !split || rem_live;
	assign new_link  = split ? rem_idx : nx_q;
	assign pv_live   = (CW'(pv_q) < HEAP_C);
	assign nx_live   = (CW'(nx_q) < HEAP_C);
	assign head_live = (CW'(head_q) < HEAP_C);
	assign bump_fits = (CW'(bump_q) >= CW'(n_q));
	assign bump_new  = bump_q - LW'(n_q);
	assign start_idx = LW'(start_q);
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (in_free) begin
						state_d = in_free_ok ? ST_FREE_RD : ST_RESP;
					end else begin
						state_d = in_zero ? ST_RESP : ST_WALK_RD;
					end
				end
			end
			ST_WALK_RD: begin
				state_d = walk_more ? ST_WALK_CHK : ST_RESP;
			end
			ST_WALK_CHK: begin
				state_d = fit ? ST_TAKE : ST_WALK_RD;
			end
			ST_TAKE: begin
				priority if (link_ok && pv_live) begin
					state_d = ST_PV_RD;
				end else if (link_ok && nx_live) begin
					state_d = ST_NX_RD;
				end else begin
					state_d = ST_CUR_CLR;
				end
			end
			ST_PV_RD: begin
				state_d = ST_PV_WR;
			end
			ST_PV_WR: begin
				state_d = nx_live ? ST_NX_RD : ST_CUR_CLR;
			end
			ST_NX_RD: begin
				state_d = ST_NX_WR;
			end
			ST_NX_WR: begin
				state_d = (kind_q == REQ_FREE) ? ST_RESP : ST_CUR_CLR;
			end
			ST_CUR_CLR: begin
				state_d = ST_RESP;
			end
			ST_FREE_RD: begin
				state_d = ST_FREE_CHK;
			end
			ST_FREE_CHK: begin
				state_d = ((rd_len == '0) && head_live) ? ST_NX_RD : ST_RESP;
			end
			ST_RESP: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ram access and handshake outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q[AW-1:0];
		mem_wdata = '0;
		mem_raddr = cur_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {LEN_W'(0), NIL, NIL};
			end
			ST_TAKE: begin
				mem_we    = split && rem_live;
				mem_waddr = rem_idx[AW-1:0];
				mem_wdata = {len_q - n_q, nx_q, pv_q};
			end
			ST_PV_RD: begin
				mem_raddr = pv_q[AW-1:0];
			end
			ST_PV_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pv_q[AW-1:0];
				mem_wdata = {rd_len, link_q, rd_prev};
			end
			ST_NX_RD: begin
				mem_raddr = nx_q[AW-1:0];
			end
			ST_NX_WR: begin
				mem_we    = 1'b1;
				mem_waddr = nx_q[AW-1:0];
				mem_wdata = {rd_len, rd_next, nx_prev_q};
			end
			ST_CUR_CLR: begin
				mem_we    = 1'b1;
				mem_wdata = {LEN_W'(0), NIL, NIL};
			end
			ST_FREE_RD: begin
				mem_raddr = start_idx[AW-1:0];
			end
			ST_FREE_CHK: begin
				mem_we    = (rd_len == '0);
				mem_waddr = start_idx[AW-1:0];
				mem_wdata = {n_q, head_q, NIL};
			end
			ST_IDLE, ST_WALK_RD, ST_WALK_CHK, ST_RESP: begin
				mem_raddr = cur_q[AW-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			head_q      <= NIL;
			bump_q      <= NIL;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// clearing pass counter
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			// bump pointer takes pages when the walk finds nothing
			if (state_q == ST_WALK_RD && !walk_more && bump_fits) begin
				bump_q <= bump_new;
			end
			// list head follows unlink, split and free
			if (state_q == ST_TAKE && link_ok && head_q == cur_q) begin
				head_q <= new_link;
			end
			if (state_q == ST_FREE_CHK && rd_len == '0) begin
				head_q <= start_idx;
			end
			// output word valid
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request, walk and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					kind_q   <= req.req_type;
					n_q      <= req.page_count;
					start_q  <= req.run_start;
					cur_q    <= head_q;
					steps_q  <= '0;
					result_q <= '0;
					status_q <= (!in_free && in_zero) ? STATUS_NOMEM : STATUS_OK;
				end
			end
			ST_WALK_RD: begin
				if (!walk_more) begin
					if (bump_fits) begin
						result_q <= bump_new;
					end else begin
						status_q <= STATUS_NOMEM;
					end
				end
			end
			ST_WALK_CHK: begin
				if (fit) begin
					len_q    <= rd_len;
					nx_q     <= rd_next;
					pv_q     <= rd_prev;
					result_q <= cur_q;
				end else begin
					cur_q   <= rd_next;
					steps_q <= steps_q + LW'(1);
				end
			end
			ST_TAKE: begin
				link_q    <= new_link;
				nx_prev_q <= split ? rem_idx : pv_q;
			end
			ST_FREE_CHK: begin
				nx_q      <= head_q;
				nx_prev_q <= start_idx;
			end
			default: begin
				len_q <= len_q;
			end
		endcase
		// output word
		if (rsp_load) begin
			rsp_q.alloc_start <= START_W'(result_q);
			rsp_q.status      <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* tb/first_fit_page_run_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator_unit_tb
// Self-checking bench for the first-fit page run allocator. A queue-fed driver
// offers request words and a monitor checks every response word against a
// heap model kept in the bench. The words start with directed corner cases,
// then follow random allocate and free traffic that mostly returns pages the
// block really handed out. Both handshakes idle at varying rates, and the
// bench includes one long output hold and three full drains.
// ----------------------------------------------------------------------------
module first_fit_page_run_allocator_unit_tb;
	import ffpra_pkg::*;

	localparam int PAGES = HEAP_PAGES_DEF;
	localparam logic [COUNT_W-1:0] NIL_LINK = COUNT_W'(PAGES);
	localparam int RANDOM_WORDS = 630;

	typedef struct packed {
		logic [START_W-1:0] first;
		logic [COUNT_W-1:0] pages;
	} held_run_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	ffpra_req_t req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	ffpra_rsp_t rsp;

	// heap model state
	logic [COUNT_W-1:0] run_len  [PAGES];
	logic [COUNT_W-1:0] next_lnk [PAGES];
	logic [COUNT_W-1:0] prev_lnk [PAGES];
	logic [COUNT_W-1:0] list_head;
	logic [COUNT_W-1:0] bump_top;

	ffpra_req_t req_pending_q[$];
	ffpra_rsp_t rsp_due_q[$];
	held_run_t  owned_runs[$];

	bit word_taken = 1'b0;
	bit track_runs = 1'b0;
	int words_made = 0;
	int words_in = 0;
	int errors = 0;
	int n_granted = 0;
	int n_refused = 0;
	int n_frees = 0;
	int send_idle_pct;
	int recv_stall_pct;

	first_fit_page_run_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// idling rates: sender light and receiver heavy, then swapped, then none
	assign send_idle_pct  = (words_in < 220) ? 16 : (words_in < 440) ? 69 : 0;
	assign recv_stall_pct = (words_in < 220) ? 69 : (words_in < 440) ? 16 : 0;

	// apply one request word to the heap model and return its response word
	function automatic ffpra_rsp_t apply_to_heap(ffpra_req_t w);
		ffpra_rsp_t o;
		int n, s, cur, steps, nx, pv, len, rem;
		bit hit;
		o.alloc_start = '0;
		o.status = STATUS_OK;
		n = int'(w.page_count);
		s = int'(w.run_start);
		if (ffpra_kind_t'(w.req_type) == REQ_ALLOC) begin
			if (n == 0) begin
				o.status = STATUS_NOMEM;
			end else begin
				cur = int'(list_head);
				steps = 0;
				hit = 1'b0;
				// first-fit walk, bounded and never through a bad link
				while (cur < PAGES && steps < PAGES && !hit) begin
					if (int'(run_len[cur]) >= n) begin
						hit = 1'b1;
						o.alloc_start = START_W'(cur);
						nx = int'(next_lnk[cur]);
						pv = int'(prev_lnk[cur]);
						len = int'(run_len[cur]);
						if (len > n) begin
							// split: remainder takes the run's list slot
							rem = cur + n;
							if (rem < PAGES) begin
								run_len[rem] = COUNT_W'(len - n);
								prev_lnk[rem] = COUNT_W'(pv);
								next_lnk[rem] = COUNT_W'(nx);
								if (pv < PAGES) next_lnk[pv] = COUNT_W'(rem);
								if (nx < PAGES) prev_lnk[nx] = COUNT_W'(rem);
								if (int'(list_head) == cur) list_head = COUNT_W'(rem);
							end
						end else begin
							// exact fit: unlink
							if (pv < PAGES) next_lnk[pv] = COUNT_W'(nx);
							if (nx < PAGES) prev_lnk[nx] = COUNT_W'(pv);
							if (int'(list_head) == cur) list_head = COUNT_W'(nx);
						end
						run_len[cur] = '0;
						next_lnk[cur] = NIL_LINK;
						prev_lnk[cur] = NIL_LINK;
					end else begin
						cur = int'(next_lnk[cur]);
						steps++;
					end
				end
				// no run fits: fall back to the bump area
				if (!hit) begin
					if (int'(bump_top) >= n) begin
						bump_top = bump_top - COUNT_W'(n);
						o.alloc_start = START_W'(bump_top);
					end else begin
						o.status = STATUS_NOMEM;
					end
				end
			end
		end else if (n != 0 && n <= PAGES - s && run_len[s] == '0) begin
			// push the freed run on the list head
			run_len[s] = COUNT_W'(n);
			prev_lnk[s] = NIL_LINK;
			next_lnk[s] = list_head;
			if (list_head < NIL_LINK) prev_lnk[list_head] = COUNT_W'(s);
			list_head = COUNT_W'(s);
		end
		return o;
	endfunction

	task automatic queue_request(ffpra_kind_t kind, int count, int first);
		ffpra_req_t w;
		w.req_type = kind;
		w.page_count = COUNT_W'(count);
		w.run_start = START_W'(first);
		while (req_pending_q.size() >= 4) @(posedge clk);
		req_pending_q.push_back(w);
		words_made++;
	endtask

	// hold off until every word is in and every response is out
	task automatic wait_drained();
		while (req_pending_q.size() != 0 || words_in != words_made || rsp_due_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// driver: new word at the falling edge once the last one was taken
	always @(negedge clk) begin : drive
		logic       nv;
		ffpra_req_t nw;
		nv = req_valid;
		nw = req;
		if (arst_n && (!req_valid || word_taken)) begin
			nv = 1'b0;
			if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nv = 1'b1;
				nw = req_pending_q.pop_front();
			end
		end
		req_valid <= nv;
		req <= nw;
	end

	// receiver stall, with one long hold while the driver keeps offering words
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	always @(negedge clk) begin : receive
		logic ns;
		if (hold_left > 0) begin
			hold_left--;
			ns = 1'b1;
		end else if (!long_hold_done && words_in >= 480) begin
			long_hold_done = 1'b1;
			hold_left = 300;
			ns = 1'b1;
		end else begin
			ns = ($urandom_range(99) < recv_stall_pct);
		end
		rsp_stall <= ns;
	end

	// monitor: predict on each accepted request, check each accepted response
	always @(posedge clk) begin : watch
		ffpra_rsp_t due;
		ffpra_rsp_t got;
		word_taken = arst_n && req_valid && !req_stall;
		if (word_taken) begin
			due = apply_to_heap(req);
			rsp_due_q.push_back(due);
			words_in++;
			if (ffpra_kind_t'(req.req_type) == REQ_FREE) begin
				n_frees++;
			end else if (due.status == STATUS_OK) begin
				n_granted++;
				if (track_runs)
					owned_runs.push_back('{first: due.alloc_start, pages: req.page_count});
			end else begin
				n_refused++;
			end
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = rsp;
			if (rsp_due_q.size() == 0) begin
				errors++;
				$display("%0t unexpected response word: expected none, got start %0d status %0d",
					$time, got.alloc_start, got.status);
			end else begin
				due = rsp_due_q.pop_front();
				if (got.alloc_start !== due.alloc_start) begin
					errors++;
					$display("%0t alloc_start mismatch: expected %0d, got %0d",
						$time, due.alloc_start, got.alloc_start);
				end
				if (got.status !== due.status) begin
					errors++;
					$display("%0t status mismatch: expected %0d, got %0d",
						$time, due.status, got.status);
				end
			end
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int pick, k, s, n;
		held_run_t hr;
		for (int i = 0; i < PAGES; i++) begin
			run_len[i] = '0;
			next_lnk[i] = NIL_LINK;
			prev_lnk[i] = NIL_LINK;
		end
		list_head = NIL_LINK;
		bump_top = COUNT_W'(PAGES);
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed corners: bump path, refusals, splits, exact fits, bad frees
		queue_request(REQ_ALLOC, 1, 0);
		queue_request(REQ_ALLOC, 7, 4095);
		queue_request(REQ_ALLOC, 0, 0);
		queue_request(REQ_ALLOC, 8191, 4095);
		queue_request(REQ_ALLOC, PAGES, 0);
		queue_request(REQ_FREE, 1, 4095);
		queue_request(REQ_FREE, 1, 4095);
		queue_request(REQ_FREE, 7, 4088);
		queue_request(REQ_ALLOC, 4090, 0);
		queue_request(REQ_FREE, 0, 0);
		queue_request(REQ_FREE, 97, 4000);
		queue_request(REQ_FREE, PAGES, 1);
		queue_request(REQ_ALLOC, 1, 0);
		queue_request(REQ_ALLOC, 6, 0);
		queue_request(REQ_ALLOC, 2, 0);
		queue_request(REQ_ALLOC, 1, 0);
		// overlapping frees, then take both pieces back
		queue_request(REQ_FREE, 2, 4086);
		queue_request(REQ_FREE, 1, 4087);
		queue_request(REQ_ALLOC, 2, 0);
		queue_request(REQ_ALLOC, 1, 0);
		wait_drained();
		track_runs = 1'b1;

		// random traffic, mostly returning pages actually owned
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 300) wait_drained();
			pick = $urandom_range(99);
			if (pick < 8) begin
				s = $urandom_range(PAGES - 1);
				case ($urandom_range(3))
					0: queue_request(REQ_ALLOC, 0, s);
					1: queue_request(REQ_ALLOC, $urandom_range(8191, PAGES + 1), s);
					2: queue_request(REQ_FREE, 0, s);
					default: queue_request(REQ_FREE, $urandom_range(8191, PAGES - s + 1), s);
				endcase
			end else if (owned_runs.size() != 0 && pick < 30 + owned_runs.size()) begin
				k = $urandom_range(owned_runs.size() - 1);
				hr = owned_runs[k];
				owned_runs.delete(k);
				queue_request(REQ_FREE, hr.pages, hr.first);
				// an immediate second free of the same run is ignored
				if ($urandom_range(9) == 0) queue_request(REQ_FREE, hr.pages, hr.first);
			end else begin
				k = $urandom_range(99);
				if (k < 60) n = $urandom_range(16, 1);
				else if (k < 90) n = $urandom_range(128, 17);
				else if (k < 98) n = $urandom_range(1024, 129);
				else n = $urandom_range(PAGES, 1025);
				queue_request(REQ_ALLOC, n, $urandom_range(PAGES - 1));
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		$display("run covered %0d request words: %0d allocations granted, %0d refused, %0d frees",
			words_in, n_granted, n_refused, n_frees);
		$display("bump and free-list paths, splits, exact fits, bad frees, long hold and drain");
		if (errors == 0)
			$display("first_fit_page_run_allocator_unit test passed");
		else
			$display("first_fit_page_run_allocator_unit test failed");
		$finish;
	end

	// watchdog
	initial begin
		#(50_000_000);
		$display("first_fit_page_run_allocator_unit test failed");
		$finish;
	end

endmodule
